// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/acl_pkg.sv =====
package acl_pkg;

  // Field widths fixed by the item format.
  localparam int RANK_W  = 11;
  localparam int LEVEL_W = 11;
  // Tree positions need one more bit, since an upward walk may step past the bound.
  localparam int POS_W   = RANK_W + 1;
  localparam int RANK_MAX = 2047;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX      = 11'd2047;
  localparam logic [RANK_W-1:0]  N_POINTS_RESET = 11'd1024;
  localparam int                 MAX_POINTS_DEF = 1024;

  // Command codes of the input item.
  localparam logic CMD_CLEAR  = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [RANK_W-1:0] rank;
    logic              colour;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               is_generator;
    logic [LEVEL_W-1:0] longest;
  } res_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // latch a new item and set up the query walk
    logic q_step;    // read both trees and step the position down
    logic calc;      // form level, generator flag and longest level
    logic u_init;    // start the update walk at the rank
    logic u_step;    // read the own tree and step the position up
    logic clr_step;  // zero one entry of both trees
    logic out_load;  // load the result register
    logic out_zero;  // load an all-zero result instead
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pos_zero;
    logic pos_over;
    logic clr_last;
  } dp_status_t;

endpackage

// ===== hdl/alternating_colour_lis_level.sv =====
// Channel  Direction  Handshake                Payload
// in_      input      in_valid / in_stall      acl_pkg::in_item_t   (cmd, rank, colour)
// out_     output     out_valid / out_stall    acl_pkg::res_item_t  (level, is_generator,
//                                                                    longest)
// cfg_     input      cfg_we                   n_points, 11 bits
//
// Between input transfers a point passes acceptance, the query walk, the level, the update
// walk and the result hand-off. The walks move one tree position per cycle through each
// tree's single read port. Reset and a clear command each run a clearing pass over all
// MAX_POINTS entries, one entry of both trees per cycle, with the input stalled. A stalled
// result does not hold the input; the block waits only when a further result finds the
// output full.
module alternating_colour_lis_level #(
  parameter int MAX_POINTS = acl_pkg::MAX_POINTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  acl_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output acl_pkg::res_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [acl_pkg::RANK_W-1:0] cfg_data
);

  acl_pkg::dp_cmd_t    dp_cmd;
  acl_pkg::dp_status_t dp_status;

  // Sequencer for the clearing pass, the two tree walks and the result hand-off.
  acl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  // Tree memories, walk position and result register.
  acl_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (dp_cmd),
    .status   (dp_status),
    .out_data (out_data)
  );

endmodule

// ===== hdl/acl_ctrl.sv =====
`include "assert_macros.svh"

module acl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_cmd,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  acl_pkg::dp_status_t status,
  output acl_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_QUERY,
    S_LEVEL,
    S_UPDATE,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   clr_reply_r, clr_reply_nxt;
  logic   in_xfer;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // Next state and datapath commands.
  always_comb begin
    state_nxt     = state_r;
    clr_reply_nxt = clr_reply_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_nxt = clr_reply_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          cmd.load = 1'b1;
          if (in_cmd == acl_pkg::CMD_CLEAR) begin
            state_nxt     = S_CLEAR;
            clr_reply_nxt = 1'b1;
          end else begin
            state_nxt     = S_QUERY;
            clr_reply_nxt = 1'b0;
          end
        end
      end
      S_QUERY: begin
        if (status.pos_zero) begin
          state_nxt = S_LEVEL;
        end else begin
          cmd.q_step = 1'b1;
        end
      end
      S_LEVEL: begin
        cmd.calc   = 1'b1;
        cmd.u_init = 1'b1;
        state_nxt  = S_UPDATE;
      end
      S_UPDATE: begin
        if (status.pos_zero || status.pos_over) begin
          state_nxt = S_DONE;
        end else begin
          cmd.u_step = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_zero  = clr_reply_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // State and registered outputs; reset starts with a clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
      clr_reply_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clr_reply_r <= clr_reply_nxt;
    end
  end

  // A new result only appears from the completion state.
  `ASSERT_SAME(a_out_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r == S_DONE))
  // The clearing pass is not cut short.
  `ASSERT_NEXT(a_clear_holds, clk, rst_n, state_r == S_CLEAR && !status.clr_last,
               state_r == S_CLEAR)

endmodule

// ===== hdl/acl_dpath.sv =====
`include "assert_macros.svh"

module acl_dpath #(
  parameter int MAX_POINTS = acl_pkg::MAX_POINTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  acl_pkg::in_item_t                     in_data,
  input  logic                                  cfg_we,
  input  logic [acl_pkg::RANK_W-1:0]            cfg_data,
  input  acl_pkg::dp_cmd_t                      cmd,
  output acl_pkg::dp_status_t                   status,
  output acl_pkg::res_item_t                    out_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int PW = acl_pkg::POS_W;
  localparam int RW = acl_pkg::RANK_W;
  localparam int LW = acl_pkg::LEVEL_W;
  localparam logic [RW-1:0] BOUND_CAP =
    RW'(MAX_POINTS > acl_pkg::RANK_MAX ? acl_pkg::RANK_MAX : MAX_POINTS);

  // Tree memories, one per colour; position p lives at address p - 1.
  logic [LW-1:0] tree0_mem [MAX_POINTS];
  logic [LW-1:0] tree1_mem [MAX_POINTS];

  logic [RW-1:0] n_points_r;
  logic [RW-1:0] rank_r;
  logic          colour_r;
  logic [RW-1:0] bound_r;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [LW-1:0] other_max_r, own_max_r;
  logic [LW-1:0] lvl_r, longest_r;
  logic          gen_r;
  logic          q_vld_r, u_vld_r;
  logic [AW-1:0] u_addr_r;
  logic [AW-1:0] clr_cnt_r;
  logic [LW-1:0] rd0_r, rd1_r;
  acl_pkg::res_item_t out_r;

  logic [RW-1:0]    bound_nxt, rank_m1, top;
  logic [PW-1:0]    low_bit, pos_m1;
  logic [PW+AW-1:0] pos_ext;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [LW-1:0]    dout_own, dout_other, wr_data, lvl_nxt;
  logic             we0, we1;

  // Effective bound and the first query position for an arriving item.
  assign bound_nxt = (n_points_r < BOUND_CAP) ? n_points_r : BOUND_CAP;
  assign rank_m1   = (in_data.rank == '0) ? '0 : in_data.rank - RW'(1);
  assign top       = (rank_m1 > bound_nxt) ? bound_nxt : rank_m1;

  // Lowest set bit and memory address of the current position.
  assign low_bit = pos_r & (~pos_r + PW'(1));
  assign pos_m1  = pos_r - PW'(1);
  assign pos_ext = {{AW{1'b0}}, pos_m1};
  assign rd_addr = pos_ext[AW-1:0];

  assign dout_own   = colour_r ? rd1_r : rd0_r;
  assign dout_other = colour_r ? rd0_r : rd1_r;
  assign lvl_nxt    = (other_max_r == acl_pkg::LEVEL_MAX) ? acl_pkg::LEVEL_MAX
                                                          : other_max_r + LW'(1);

  // Write port: the clearing pass, or the raised value of an update read.
  assign wr_data = cmd.clr_step ? '0 : ((dout_own > lvl_r) ? dout_own : lvl_r);
  assign wr_addr = cmd.clr_step ? clr_cnt_r : u_addr_r;
  assign we0     = cmd.clr_step || (u_vld_r && !colour_r);
  assign we1     = cmd.clr_step || (u_vld_r && colour_r);

  always_ff @(posedge clk) begin
    rd0_r <= tree0_mem[rd_addr];
    rd1_r <= tree1_mem[rd_addr];
    if (we0) begin
      tree0_mem[wr_addr] <= wr_data;
    end
    if (we1) begin
      tree1_mem[wr_addr] <= wr_data;
    end
  end

  // Walk position: down for the query, up for the update.
  always_comb begin
    pos_nxt = pos_r;
    if (cmd.load) begin
      pos_nxt = {1'b0, top};
    end else if (cmd.q_step) begin
      pos_nxt = pos_r - low_bit;
    end else if (cmd.u_init) begin
      pos_nxt = {1'b0, rank_r};
    end else if (cmd.u_step) begin
      pos_nxt = pos_r + low_bit;
    end
  end

  assign status.pos_zero = (pos_r == '0);
  assign status.pos_over = (pos_r > {1'b0, bound_r});
  assign status.clr_last = (clr_cnt_r == AW'(MAX_POINTS - 1));

  // Control state: configuration, read pipeline flags, sweep counter, longest.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_points_r <= acl_pkg::N_POINTS_RESET;
      q_vld_r    <= 1'b0;
      u_vld_r    <= 1'b0;
      clr_cnt_r  <= '0;
      longest_r  <= '0;
    end else begin
      if (cfg_we) begin
        n_points_r <= cfg_data;
      end
      q_vld_r <= cmd.q_step;
      u_vld_r <= cmd.u_step;
      if (cmd.clr_step) begin
        clr_cnt_r <= status.clr_last ? '0 : clr_cnt_r + AW'(1);
        longest_r <= '0;
      end else if (cmd.calc && lvl_nxt > longest_r) begin
        longest_r <= lvl_nxt;
      end
    end
  end

  // Item registers and the prefix maxima gathered over the query walk.
  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    u_addr_r <= rd_addr;
    if (cmd.load) begin
      rank_r      <= in_data.rank;
      colour_r    <= in_data.colour;
      bound_r     <= bound_nxt;
      other_max_r <= '0;
      own_max_r   <= '0;
    end else if (q_vld_r) begin
      if (dout_other > other_max_r) begin
        other_max_r <= dout_other;
      end
      if (dout_own > own_max_r) begin
        own_max_r <= dout_own;
      end
    end
    if (cmd.calc) begin
      lvl_r <= lvl_nxt;
      gen_r <= (own_max_r < lvl_nxt);
    end
    if (cmd.out_load) begin
      if (cmd.out_zero) begin
        out_r <= '0;
      end else begin
        out_r.level        <= lvl_r;
        out_r.is_generator <= gen_r;
        out_r.longest      <= longest_r;
      end
    end
  end

  assign out_data = out_r;

  // A computed level is never zero.
  `ASSERT_NEXT(a_level_nonzero, clk, rst_n, cmd.calc, lvl_r != '0)
  // The running longest level covers the level just formed.
  `ASSERT_NEXT(a_longest_covers, clk, rst_n, cmd.calc, longest_r >= lvl_r)

endmodule
